// ===== rtl/core/rv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rv_pkg;

	// Configuration register widths.
	localparam int DIM_W    = 13;
	localparam int FACT_W   = 11;
	localparam int M2_W     = 2 * DIM_W + 1;

	// Q1.10 arithmetic.
	localparam int FRAC_BITS = 10;
	localparam int QUO_BITS  = 2 * FRAC_BITS;
	localparam int ROOT_BITS = FRAC_BITS;
	localparam logic [FACT_W-1:0] ONE_Q10 = FACT_W'(1 << FRAC_BITS);

	// Register indexes on the configuration port.
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_STRENGTH = 2'd2;
	localparam logic [1:0] REG_MIN_FACT = 2'd3;

	typedef struct packed {
		logic [DIM_W-1:0]  image_width;
		logic [DIM_W-1:0]  image_height;
		logic [FACT_W-1:0] strength;
		logic [FACT_W-1:0] min_factor;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/rv_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rv_cfg (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [rv_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]              pwdata,
	output logic      [31:0]              prdata,
	output logic                          pready,
	output rv_pkg::cfg_t                  cfg,
	output logic      [rv_pkg::M2_W-1:0]  m2
);
	import rv_pkg::*;

	cfg_t                cfg_q;
	logic [2*DIM_W-1:0]  wsq_q;
	logic [2*DIM_W-1:0]  hsq_q;
	logic [M2_W-1:0]     m2_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= DIM_W'(640);
			cfg_q.image_height <= DIM_W'(480);
			cfg_q.strength     <= FACT_W'(717);
			cfg_q.min_factor   <= FACT_W'(307);
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_WIDTH:    cfg_q.image_width  <= pwdata[DIM_W-1:0];
				REG_HEIGHT:   cfg_q.image_height <= pwdata[DIM_W-1:0];
				REG_STRENGTH: cfg_q.strength     <= pwdata[FACT_W-1:0];
				REG_MIN_FACT: cfg_q.min_factor   <= pwdata[FACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:    prdata = 32'(cfg_q.image_width);
			REG_HEIGHT:   prdata = 32'(cfg_q.image_height);
			REG_STRENGTH: prdata = 32'(cfg_q.strength);
			REG_MIN_FACT: prdata = 32'(cfg_q.min_factor);
			default:      prdata = 32'd0;
		endcase
	end

	// The corner distance is registered from the registers through wsq_q, hsq_q
	// and m2_q; the user must change the registers only while no pixel is in flight, the block itself does not enforce it.
	always_ff @(posedge clk) begin
		wsq_q <= cfg_q.image_width * cfg_q.image_width;
		hsq_q <= cfg_q.image_height * cfg_q.image_height;
		m2_q  <= M2_W'(wsq_q) + M2_W'(hsq_q);
	end

	assign cfg = cfg_q;
	assign m2  = m2_q;

endmodule
`default_nettype wire

// ===== rtl/core/rv_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage. The numerator must be
// below the denominator; the quotient is floor(num * 2^Q_BITS / den).
module rv_div #(
	parameter int D_W    = 27,
	parameter int Q_BITS = 20,
	parameter int SIDE_W = 25
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [D_W-1:0]    in_num,
	input  wire logic [D_W-1:0]    in_den,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [Q_BITS-1:0]      out_quo,
	output logic [SIDE_W-1:0]      out_side
);
	logic              v_sk    [0:Q_BITS-1];
	logic [D_W-1:0]    rem_sk  [0:Q_BITS-1];
	logic [Q_BITS-1:0] quo_sk  [0:Q_BITS-1];
	logic [SIDE_W-1:0] side_sk [0:Q_BITS-1];

	for (genvar k = 0; k < Q_BITS; k++) begin : g_step
		logic              v_prev;
		logic [D_W-1:0]    rem_prev;
		logic [Q_BITS-1:0] quo_prev;
		logic [SIDE_W-1:0] side_prev;
		logic [D_W:0]      r2;
		logic [D_W:0]      diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_prev    = in_valid;
			assign rem_prev  = in_num;
			assign quo_prev  = '0;
			assign side_prev = in_side;
		end else begin : g_next
			assign v_prev    = v_sk[k-1];
			assign rem_prev  = rem_sk[k-1];
			assign quo_prev  = quo_sk[k-1];
			assign side_prev = side_sk[k-1];
		end

		assign r2   = {rem_prev, 1'b0};
		assign diff = r2 - {1'b0, in_den};
		assign ge   = r2 >= {1'b0, in_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else if (en) begin
				v_sk[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k]  <= ge ? diff[D_W-1:0] : r2[D_W-1:0];
				quo_sk[k]  <= {quo_prev[Q_BITS-2:0], ge};
				side_sk[k] <= side_prev;
			end
		end
	end

	assign out_valid = v_sk[Q_BITS-1];
	assign out_quo   = quo_sk[Q_BITS-1];
	assign out_side  = side_sk[Q_BITS-1];

endmodule
`default_nettype wire

// ===== rtl/core/rv_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Digit-by-digit integer square root, one root bit per stage.
module rv_sqrt #(
	parameter int Q_W    = 20,
	parameter int SIDE_W = 25
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [Q_W-1:0]    in_val,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [Q_W/2-1:0]       out_root,
	output logic [SIDE_W-1:0]      out_side
);
	localparam int R_W  = Q_W / 2;
	localparam int RM_W = R_W + 2;

	logic              v_sk    [0:R_W-1];
	logic [Q_W-1:0]    val_sk  [0:R_W-1];
	logic [RM_W-1:0]   rem_sk  [0:R_W-1];
	logic [R_W-1:0]    root_sk [0:R_W-1];
	logic [SIDE_W-1:0] side_sk [0:R_W-1];

	for (genvar k = 0; k < R_W; k++) begin : g_step
		logic              v_prev;
		logic [Q_W-1:0]    val_prev;
		logic [RM_W-1:0]   rem_prev;
		logic [R_W-1:0]    root_prev;
		logic [SIDE_W-1:0] side_prev;
		logic [RM_W+1:0]   cur;
		logic [RM_W+1:0]   trial;
		logic [RM_W+1:0]   diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_prev    = in_valid;
			assign val_prev  = in_val;
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign side_prev = in_side;
		end else begin : g_next
			assign v_prev    = v_sk[k-1];
			assign val_prev  = val_sk[k-1];
			assign rem_prev  = rem_sk[k-1];
			assign root_prev = root_sk[k-1];
			assign side_prev = side_sk[k-1];
		end

		// Bring down the next pair of bits, most significant pair first.
		assign cur   = {rem_prev, val_prev[Q_W-1-2*k -: 2]};
		assign trial = (RM_W+2)'({root_prev, 2'b01});
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else if (en) begin
				v_sk[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				val_sk[k]  <= val_prev;
				rem_sk[k]  <= ge ? diff[RM_W-1:0] : cur[RM_W-1:0];
				root_sk[k] <= {root_prev[R_W-2:0], ge};
				side_sk[k] <= side_prev;
			end
		end
	end

	assign out_valid = v_sk[R_W-1];
	assign out_root  = root_sk[R_W-1];
	assign out_side  = side_sk[R_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/radial_vignette_pixel_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Kind              Contents
// s_*       stream in         pixel request: position and color
// m_*       stream out        darkened color
// p*        register port     width, height, strength, min_factor
//
// One pixel per clock, back to back, unless the output stalls; the pipeline
// has three front stages, twenty divider stages, ten square-root stages and
// three back stages. The divider and square root are unrolled, one bit per
// stage. Reset clears every valid bit and loads the register defaults. A
// stall at the output freezes the whole pipeline and drops s_tready.
module radial_vignette_pixel_unit #(
	parameter int MAX_DIM      = 4096,
	parameter int CHANNEL_BITS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// pos_x, pos_y, red_in, green_in, blue_in
	input  wire logic [((2*$clog2(MAX_DIM)+3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// red_out, green_out, blue_out
	output logic [((3*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rv_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready
);
	import rv_pkg::*;

	localparam int POS_W  = $clog2(MAX_DIM);
	localparam int CB     = CHANNEL_BITS;
	localparam int CH_W   = 3 * CB;
	localparam int AW     = (POS_W + 1 > DIM_W) ? POS_W + 1 : DIM_W;
	localparam int DW     = (2 * AW + 1 > M2_W) ? 2 * AW + 1 : M2_W;
	localparam int SIDE_W = CH_W + 1;
	localparam int OUT_W  = ((3 * CB + 7) / 8) * 8;
	localparam logic [CB-1:0] CHAN_MAX = '1;

	cfg_t            cfg;
	logic [M2_W-1:0] m2;
	logic            en;

	rv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.m2      (m2)
	);

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Front end: distances from the center in doubled coordinates.
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic [AW:0]      dx;
	logic [AW:0]      dy;

	assign pos_x = s_tdata[POS_W-1:0];
	assign pos_y = s_tdata[2*POS_W-1:POS_W];
	assign dx = {1'b0, AW'({pos_x, 1'b0})} - {1'b0, AW'(cfg.image_width)};
	assign dy = {1'b0, AW'({pos_y, 1'b0})} - {1'b0, AW'(cfg.image_height)};

	logic            v_s1, v_s2, v_s3;
	logic [AW-1:0]   adx_s1, ady_s1;
	logic [CH_W-1:0] ch_s1, ch_s2, ch_s3;
	logic [2*AW-1:0] sqx_s2, sqy_s2;
	logic [DW-1:0]   d2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1 <= dx[AW] ? AW'(-dx) : dx[AW-1:0];
			ady_s1 <= dy[AW] ? AW'(-dy) : dy[AW-1:0];
			ch_s1  <= s_tdata[2*POS_W +: CH_W];
			sqx_s2 <= adx_s1 * adx_s1;
			sqy_s2 <= ady_s1 * ady_s1;
			ch_s2  <= ch_s1;
			d2_s3  <= DW'(sqx_s2) + DW'(sqy_s2);
			ch_s3  <= ch_s2;
		end
	end

	// A pixel at or beyond the corner distance, or an empty image, takes
	// the full ratio; the divider result is then ignored.
	logic               sat3;
	logic               div_v;
	logic [QUO_BITS-1:0] div_q;
	logic [SIDE_W-1:0]  div_side;

	assign sat3 = d2_s3 >= DW'(m2);

	rv_div #(
		.D_W    (DW),
		.Q_BITS (QUO_BITS),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_num    (d2_s3),
		.in_den    (DW'(m2)),
		.in_side   ({sat3, ch_s3}),
		.out_valid (div_v),
		.out_quo   (div_q),
		.out_side  (div_side)
	);

	logic                 sq_v;
	logic [ROOT_BITS-1:0] sq_root;
	logic [SIDE_W-1:0]    sq_side;

	rv_sqrt #(
		.Q_W    (QUO_BITS),
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_v),
		.in_val    (div_q),
		.in_side   (div_side),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// Back end: brightness factor and channel scaling.
	logic [FACT_W-1:0]   ratio;
	logic [2*FACT_W-1:0] prod;
	logic                v_s4, v_s5, v_s6;
	logic [FACT_W:0]     drop_s4;
	logic [CH_W-1:0]     ch_s4, ch_s5;
	logic [FACT_W-1:0]   factor_s5;
	logic [FACT_W-1:0]   factor;
	logic [CH_W-1:0]     res;
	logic [OUT_W-1:0]    out_s6;

	assign ratio = sq_side[CH_W] ? ONE_Q10 : FACT_W'(sq_root);
	assign prod  = ratio * cfg.strength;

	always_comb begin
		if (drop_s4 >= (FACT_W+1)'(ONE_Q10)) begin
			factor = '0;
		end else begin
			factor = ONE_Q10 - drop_s4[FACT_W-1:0];
		end
		if (factor < cfg.min_factor) begin
			factor = cfg.min_factor;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [CB+FACT_W-1:0] p;
		logic [CB+FACT_W-FRAC_BITS-1:0] v;

		assign p = ch_s5[c*CB +: CB] * factor_s5;
		assign v = p[CB+FACT_W-1:FRAC_BITS];
		assign res[c*CB +: CB] = (v > (CB+FACT_W-FRAC_BITS)'(CHAN_MAX)) ? CHAN_MAX : v[CB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drop_s4   <= prod[2*FACT_W-1:FRAC_BITS];
			ch_s4     <= sq_side[CH_W-1:0];
			factor_s5 <= factor;
			ch_s5     <= ch_s4;
			out_s6    <= OUT_W'(res);
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = out_s6;

	a_factor_floor : assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> factor_s5 >= cfg.min_factor)
		else $error("factor below min_factor");

	a_factor_range : assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (factor_s5 <= ONE_Q10 || factor_s5 == cfg.min_factor))
		else $error("factor above unity without min_factor");

	a_stall_only : assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input held off without an output stall");

	a_freeze : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en) |=> (v_s5 && $stable(factor_s5)))
		else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// ===== verif/vignette_checker.sv =====
`timescale 1ns / 1ps
module vignette_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [47:0] s_tdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending_pixels
);
	import rv_pkg::*;

	cfg_t cfg;
	logic [23:0] expected_pixels[$];

	function automatic logic [10:0] root_q10(input logic [19:0] v);
		logic [10:0] r;
		r = 0;
		for (int b = 9; b >= 0; b--) begin
			if ((r | (11'd1 << b)) * (r | (11'd1 << b)) <= v)
				r = r | (11'd1 << b);
		end
		return r;
	endfunction

	function automatic logic [7:0] darken(input logic [7:0] c, input logic [10:0] f);
		logic [18:0] v;
		v = (c * f) >> 10;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic logic [23:0] vignette(input logic [47:0] px);
		longint dx, dy, d2, m2, q, ratio, drop, factor;
		dx = 2 * longint'(px[11:0]) - longint'(cfg.image_width);
		dy = 2 * longint'(px[23:12]) - longint'(cfg.image_height);
		d2 = dx * dx + dy * dy;
		m2 = longint'(cfg.image_width) * cfg.image_width
			+ longint'(cfg.image_height) * cfg.image_height;
		if (m2 == 0) begin
			ratio = 1024;
		end else begin
			q = (d2 << 20) / m2;
			ratio = (q >= 1048576) ? 1024 : longint'(root_q10(q[19:0]));
		end
		drop = (ratio * cfg.strength) >> 10;
		factor = (drop >= 1024) ? 0 : 1024 - drop;
		if (factor < cfg.min_factor)
			factor = cfg.min_factor;
		return {darken(px[47:40], factor[10:0]), darken(px[39:32], factor[10:0]),
			darken(px[31:24], factor[10:0])};
	endfunction

	assign pending_pixels = expected_pixels.size();

	always @(posedge clk or negedge arst_n) begin
		logic [23:0] want;
		if (!arst_n) begin
			cfg.image_width <= 13'd640;
			cfg.image_height <= 13'd480;
			cfg.strength <= 11'd717;
			cfg.min_factor <= 11'd307;
			fail_count <= 0;
			expected_pixels.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_WIDTH:    cfg.image_width <= pwdata[12:0];
					REG_HEIGHT:   cfg.image_height <= pwdata[12:0];
					REG_STRENGTH: cfg.strength <= pwdata[10:0];
					REG_MIN_FACT: cfg.min_factor <= pwdata[10:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_pixels.push_back(vignette(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected pixel %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (want[7:0] !== m_tdata[7:0])
						$error("red_out expected %0d got %0d", want[7:0], m_tdata[7:0]);
					if (want[15:8] !== m_tdata[15:8])
						$error("green_out expected %0d got %0d", want[15:8], m_tdata[15:8]);
					if (want[23:16] !== m_tdata[23:16])
						$error("blue_out expected %0d got %0d", want[23:16], m_tdata[23:16]);
					if (want !== m_tdata)
						fail_count <= fail_count + 1;
				end
			end
		end
	end
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import rv_pkg::*;

	logic        clk;
	logic        arst_n;
	logic [47:0] s_tdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending_pixels;
	int          send_gap_pct;
	int          recv_gap_pct;
	int          hold_off;
	logic        hold_req;
	logic        hold_ack;
	int          quiet_cycles;

	radial_vignette_pixel_unit uut (.*);

	vignette_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			hold_off <= 0;
			hold_ack <= 0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_off <= 300;
			m_tready <= 0;
		end else if (hold_off > 0) begin
			m_tready <= 0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// The watchdog counts cycles in which no request moves on either side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 5000) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic set_image(input int w, input int h, input int st, input int mf);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_STRENGTH, st);
		write_reg(REG_MIN_FACT, mf);
	endtask

	// Valid stays high from one request to the next unless the sender idles.
	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {b, g, r, y, x};
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending_pixels != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic random_pixels(input int n, input int w, input int h);
		int xmax, ymax;
		xmax = (w > 4095) ? 4095 : w;
		ymax = (h > 4095) ? 4095 : h;
		repeat (n) begin
			if ($urandom_range(9) == 0)
				send_pixel(12'($urandom), 12'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
			else
				send_pixel(12'($urandom_range(xmax)), 12'($urandom_range(ymax)),
					8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int w, h;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		hold_req = 0;
		send_gap_pct = 0;
		recv_gap_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// Directed: corners, center, channel extremes, with reset settings.
		send_pixel(0, 0, 255, 255, 255);
		send_pixel(320, 240, 255, 0, 128);
		send_pixel(639, 479, 1, 254, 255);
		send_pixel(4095, 4095, 255, 255, 255);
		send_pixel(0, 240, 170, 85, 0);
		drain();
		// Zero-sized image, strength above one, min_factor above one.
		set_image(0, 0, 2047, 0);
		send_pixel(0, 0, 255, 255, 255);
		send_pixel(100, 7, 200, 100, 50);
		drain();
		set_image(1, 1, 2047, 2047);
		send_pixel(0, 0, 255, 128, 1);
		send_pixel(4095, 0, 255, 255, 255);
		drain();
		set_image(8191, 8191, 1024, 0);
		send_pixel(4095, 4095, 255, 255, 255);
		send_pixel(0, 0, 255, 255, 255);
		send_pixel(2048, 100, 99, 255, 7);
		drain();
		set_image(4096, 1, 0, 1024);
		send_pixel(2048, 0, 255, 255, 255);
		send_pixel(0, 4095, 33, 66, 99);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase % 3)
				0: begin send_gap_pct = 7; recv_gap_pct = 52; end
				1: begin send_gap_pct = 52; recv_gap_pct = 7; end
				default: begin send_gap_pct = 0; recv_gap_pct = 0; end
			endcase
			w = (phase == 5) ? 4096 : $urandom_range(1, 700);
			h = (phase == 4) ? 4096 : $urandom_range(1, 700);
			set_image(w, h, $urandom_range(1100), $urandom_range(phase == 3 ? 2047 : 1024));
			if (phase == 2)
				hold_req = ~hold_req;
			random_pixels(145, w, h);
			drain();
		end
		set_image(640, 480, 717, 307);
		random_pixels(20, 640, 480);
		drain();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
